FILE: sv/tli_pkg.sv
`timescale 1ns / 1ps
package tli_pkg;

	localparam int TABLE_SPACE = 64;
	localparam int IDX_BITS = 6;
	localparam int CODE_BITS = 12;
	localparam int SAMPLE_MAX = 16;
	localparam int DEG_BITS = 8;
	localparam int TEMP_BITS = 20;
	localparam int DT_BITS = 19;
	localparam int OUT_BITS = 16;

	localparam int TABLE_ENTRIES_DEF = 17;
	localparam int FRAC_BITS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 12;

	typedef enum logic {
		KIND_FIXED,
		KIND_INTERP
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic                          neg;
		logic signed [TEMP_BITS-1:0]   t1;
		logic [CODE_BITS-1:0]          off;
		logic [CODE_BITS-1:0]          span;
		logic [DT_BITS-1:0]            dt_mag;
	} item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	function automatic logic [CODE_BITS-1:0] lut_code(input logic [IDX_BITS-1:0] k);
		unique case (k)
			6'd0: lut_code = 12'd0;
			6'd1: lut_code = 12'd214;
			6'd2: lut_code = 12'd428;
			6'd3: lut_code = 12'd642;
			6'd4: lut_code = 12'd857;
			6'd5: lut_code = 12'd1071;
			6'd6: lut_code = 12'd1285;
			6'd7: lut_code = 12'd1500;
			6'd8: lut_code = 12'd1714;
			6'd9: lut_code = 12'd1928;
			6'd10: lut_code = 12'd2142;
			6'd11: lut_code = 12'd2357;
			6'd12: lut_code = 12'd2571;
			6'd13: lut_code = 12'd2785;
			6'd14: lut_code = 12'd3000;
			6'd15: lut_code = 12'd3214;
			6'd16: lut_code = 12'd3428;
			default: lut_code = 12'd0;
		endcase
	endfunction

	function automatic logic signed [DEG_BITS-1:0] lut_deg(input logic [IDX_BITS-1:0] k);
		unique case (k)
			6'd0: lut_deg = 8'sd70;
			6'd1: lut_deg = 8'sd65;
			6'd2: lut_deg = 8'sd60;
			6'd3: lut_deg = 8'sd55;
			6'd4: lut_deg = 8'sd50;
			6'd5: lut_deg = 8'sd45;
			6'd6: lut_deg = 8'sd40;
			6'd7: lut_deg = 8'sd35;
			6'd8: lut_deg = 8'sd30;
			6'd9: lut_deg = 8'sd25;
			6'd10: lut_deg = 8'sd20;
			6'd11: lut_deg = 8'sd15;
			6'd12: lut_deg = 8'sd10;
			6'd13: lut_deg = 8'sd5;
			6'd14: lut_deg = 8'sd0;
			6'd15: lut_deg = -8'sd5;
			6'd16: lut_deg = -8'sd10;
			default: lut_deg = 8'sd0;
		endcase
	endfunction

endpackage

FILE: sv/tli_front.sv
`timescale 1ns / 1ps
module tli_front import tli_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   mode_we,
	input  logic                   mode_wdata,
	input  queue_status_t          q_status,
	output logic                   push,
	output item_t                  push_item
);

	localparam int LAST = TABLE_ENTRIES - 1;
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(LAST);

	logic mode_q;
	logic [SAMPLE_MAX-1:0] xw;
	logic found;
	logic [IDX_BITS-1:0] seg;
	logic [SAMPLE_MAX-1:0] a1s;
	logic [SAMPLE_MAX-1:0] a2s;
	logic signed [TEMP_BITS-1:0] t1;
	logic signed [TEMP_BITS-1:0] t2;
	logic signed [TEMP_BITS-1:0] dt;

	function automatic logic signed [TEMP_BITS-1:0] scaled(input logic [IDX_BITS-1:0] k);
		logic signed [TEMP_BITS-1:0] v;
		v = TEMP_BITS'(lut_deg(k));
		return v <<< FRAC_BITS;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	assign push = start && !q_status.full;
	assign xw = SAMPLE_MAX'(adc_sample);

	always_comb begin : seg_search
		found = 1'b0;
		seg = '0;
		for (int k = 0; k < LAST; k++) begin
			logic [SAMPLE_MAX-1:0] lo;
			logic [SAMPLE_MAX-1:0] hi;
			lo = SAMPLE_MAX'(lut_code(IDX_BITS'(k)));
			hi = SAMPLE_MAX'(lut_code(IDX_BITS'(k + 1)));
			if (!found && xw >= lo && (mode_q ? (xw <= hi) : (xw < hi))) begin
				found = 1'b1;
				seg = IDX_BITS'(k);
			end
		end
	end

	assign a1s = SAMPLE_MAX'(lut_code(seg));
	assign a2s = SAMPLE_MAX'(lut_code(seg + 6'd1));
	assign t1 = scaled(seg);
	assign t2 = scaled(seg + 6'd1);
	assign dt = t2 - t1;

	always_comb begin
		push_item.kind = KIND_FIXED;
		push_item.neg = dt[TEMP_BITS-1];
		push_item.t1 = t1;
		push_item.off = CODE_BITS'(xw - a1s);
		push_item.span = CODE_BITS'(a2s - a1s);
		push_item.dt_mag = dt[TEMP_BITS-1] ? DT_BITS'(-dt) : DT_BITS'(dt);
		if (xw <= SAMPLE_MAX'(lut_code('0))) begin
			push_item.t1 = scaled('0);
		end else if (xw >= SAMPLE_MAX'(lut_code(LAST_IDX))) begin
			push_item.t1 = scaled(LAST_IDX);
		end else if (!found) begin
			push_item.t1 = scaled(LAST_IDX);
		end else if (mode_q && a2s > a1s) begin
			push_item.kind = KIND_INTERP;
		end
	end

endmodule

FILE: sv/tli_queue.sv
`timescale 1ns / 1ps
module tli_queue import tli_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         push_item,
	input  logic          pop,
	output queue_status_t status,
	output item_t         head
);

	localparam int DEPTH = 2;
	localparam int PTR_BITS = $clog2(DEPTH);

	item_t mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0] count_q;
	logic do_pop;

	assign status.full = (count_q == (PTR_BITS + 1)'(DEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_pop = pop && status.not_empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/tli_back.sv
`timescale 1ns / 1ps
module tli_back import tli_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  item_t                      in_item,
	output logic                       done,
	output logic signed [OUT_BITS-1:0] temperature
);

	localparam int QW = 7 + FRAC_BITS;
	localparam int NW = CODE_BITS + QW;

	typedef struct packed {
		kind_t                       kind;
		logic                        neg;
		logic signed [TEMP_BITS-1:0] t1;
		logic [CODE_BITS-1:0]        span;
		logic [CODE_BITS-1:0]        rem;
		logic [QW-1:0]               low;
		logic [QW-1:0]               quo;
	} div_stage_t;

	function automatic div_stage_t div_step(input div_stage_t s);
		div_stage_t r;
		logic [CODE_BITS:0] trial;
		r = s;
		trial = {s.rem, s.low[QW-1]};
		r.low = s.low << 1;
		if (trial >= {1'b0, s.span}) begin
			r.rem = CODE_BITS'(trial - {1'b0, s.span});
			r.quo = {s.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = trial[CODE_BITS-1:0];
			r.quo = {s.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	logic valid_s1;
	kind_t kind_s1;
	logic neg_s1;
	logic signed [TEMP_BITS-1:0] t1_s1;
	logic [CODE_BITS-1:0] span_s1;
	logic [NW-1:0] prod_s1;

	logic valid_s2 [QW];
	div_stage_t div_s2 [QW];
	div_stage_t div_in;

	logic done_s3;
	logic signed [OUT_BITS-1:0] temp_s3;
	logic signed [TEMP_BITS-1:0] quo_ext;
	logic signed [TEMP_BITS-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= in_item.kind;
		neg_s1 <= in_item.neg;
		t1_s1 <= in_item.t1;
		span_s1 <= in_item.span;
		prod_s1 <= NW'(in_item.off) * NW'(in_item.dt_mag[QW-1:0]);
	end

	always_comb begin
		div_in.kind = kind_s1;
		div_in.neg = neg_s1;
		div_in.t1 = t1_s1;
		div_in.span = span_s1;
		div_in.rem = prod_s1[NW-1:QW];
		div_in.low = prod_s1[QW-1:0];
		div_in.quo = '0;
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[j] <= 1'b0;
			end else begin
				valid_s2[j] <= (j == 0) ? valid_s1 : valid_s2[(j == 0) ? 0 : j - 1];
			end
		end
		always_ff @(posedge clk) begin
			div_s2[j] <= div_step((j == 0) ? div_in : div_s2[(j == 0) ? 0 : j - 1]);
		end
	end

	assign quo_ext = signed'(TEMP_BITS'(div_s2[QW-1].quo));

	always_comb begin
		result = div_s2[QW-1].t1;
		if (div_s2[QW-1].kind == KIND_INTERP) begin
			result = div_s2[QW-1].neg ? div_s2[QW-1].t1 - quo_ext
				: div_s2[QW-1].t1 + quo_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= valid_s2[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		temp_s3 <= result[OUT_BITS-1:0];
	end

	assign done = done_s3;
	assign temperature = temp_s3;

endmodule

FILE: sv/thermistor_lut_interpolator_top.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// -------   ------------------   -------------------------------------
// sample    start / busy         adc_sample [SAMPLE_BITS-1:0]
// result    done (1-cycle beat)  temperature [15:0], signed, FRAC_BITS frac
// config    mode_we              mode_wdata (0 step, 1 interpolate)
//
// One sample is taken every cycle; busy rises only if the front queue fills.
// A result beat follows its sample through queue, multiply, one restoring
// divide stage per quotient bit (FRAC_BITS + 7) and the output register.
// Reset clears the queue, all stage valids and sets mode to interpolate.
// The receiver cannot stall; the back end advances every cycle.
module thermistor_lut_interpolator_top import tli_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [SAMPLE_BITS-1:0]     adc_sample,
	input  logic                       mode_we,
	input  logic                       mode_wdata,
	output logic                       done,
	output logic signed [OUT_BITS-1:0] temperature
);

	localparam int LAT = FRAC_BITS + 10;

	queue_status_t q_status;
	logic push;
	item_t push_item;
	item_t head;

	tli_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRAC_BITS(FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.adc_sample(adc_sample),
		.mode_we(mode_we),
		.mode_wdata(mode_wdata),
		.q_status(q_status),
		.push(push),
		.push_item(push_item)
	);

	tli_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(q_status.not_empty),
		.status(q_status),
		.head(head)
	);

	tli_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_status.not_empty),
		.in_item(head),
		.done(done),
		.temperature(temperature)
	);

	assign busy = q_status.full;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted sample produced no result beat");

	a_result_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without a matching accepted sample");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.not_empty |=> !q_status.full)
		else $error("front queue failed to drain");

endmodule
